>>> rtl/tpwqs_pkg.sv
// Shared types and codes of the timer pool and work queue scheduler.
package tpwqs_pkg;

  localparam int TIMER_SLOTS_DEF = 8;
  localparam int WORK_DEPTH_DEF  = 16;

  localparam int OP_W   = 3;
  localparam int TIME_W = 32;
  localparam int TAG_W  = 16;
  localparam int TID_W  = 3;
  localparam int OUTC_W = 2;
  localparam int SEQ_W  = 8;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 3'd0,
    OP_START_REL = 3'd1,
    OP_START_ABS = 3'd2,
    OP_POST      = 3'd3,
    OP_RUN       = 3'd4,
    OP_CANCEL    = 3'd5
  } op_e;

  typedef enum logic [OUTC_W-1:0] {
    OUTC_DONE  = 2'd0,
    OUTC_FIRED = 2'd1,
    OUTC_WORK  = 2'd2,
    OUTC_ERROR = 2'd3
  } outcome_e;

  // One timer slot entry as stored in the slot memory.
  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [TAG_W-1:0]  tag;
    logic [SEQ_W-1:0]  order;
  } slot_t;

endpackage

>>> rtl/tpwqs_if.sv
// Valid/ready channel interfaces for scheduler operations and results.
interface tpwqs_in_if;
  logic                        valid;
  logic                        ready;
  logic [tpwqs_pkg::OP_W-1:0]   operation;
  logic [tpwqs_pkg::TIME_W-1:0] time_value;
  logic [tpwqs_pkg::TAG_W-1:0]  action_tag;
  logic [tpwqs_pkg::TID_W-1:0]  timer_id;

  modport source (output valid, output operation, output time_value, output action_tag,
                  output timer_id, input ready);
  modport sink (input valid, input operation, input time_value, input action_tag,
                input timer_id, output ready);
endinterface

interface tpwqs_out_if;
  logic                         valid;
  logic                         ready;
  logic [tpwqs_pkg::OUTC_W-1:0] outcome;
  logic [tpwqs_pkg::TAG_W-1:0]  result_tag;
  logic [tpwqs_pkg::TID_W-1:0]  result_timer;
  logic [tpwqs_pkg::TIME_W-1:0] current_time;

  modport source (output valid, output outcome, output result_tag, output result_timer,
                  output current_time, input ready);
  modport sink (input valid, input outcome, input result_tag, input result_timer,
                input current_time, output ready);
endinterface

>>> rtl/timer_pool_work_queue_scheduler.sv
// Top level: timer slot pool, idle slot FIFO and work FIFO scheduler.
//
// One operation transaction in, one result transaction out. Operations are
// handled one at a time. Run-one walks the slot memory one entry per cycle
// to find the earliest-started expired timer, and pops the work FIFO when
// none has expired and work is waiting. A finished result sits in an output
// register, so the next operation is taken while it waits. Slot data, the
// idle slot FIFO and the work FIFO live in synchronous memories; active
// flags and per-entry "written" bits of the idle FIFO are flip-flops.
module timer_pool_work_queue_scheduler #(
  parameter int TIMER_SLOTS = tpwqs_pkg::TIMER_SLOTS_DEF,
  parameter int WORK_DEPTH  = tpwqs_pkg::WORK_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpwqs_in_if.sink    in_i,
  tpwqs_out_if.source out_o
);

  localparam int SW  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int SCW = $clog2(TIMER_SLOTS + 1);
  localparam int WW  = (WORK_DEPTH > 1) ? $clog2(WORK_DEPTH) : 1;
  localparam int WCW = $clog2(WORK_DEPTH + 1);
  localparam int TW  = tpwqs_pkg::TIME_W;
  localparam int GW  = tpwqs_pkg::TAG_W;
  localparam int QW  = tpwqs_pkg::SEQ_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DEC   = 3'd3;
  localparam logic [2:0] ST_WORK  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]             state_q;
  logic [TW-1:0]          tick_q;
  logic [QW-1:0]          seq_q;
  logic [TIMER_SLOTS-1:0] active_q;
  logic [TIMER_SLOTS-1:0] idle_wr_q;
  logic [SW-1:0]          idle_head_q;
  logic [SCW-1:0]         idle_cnt_q;
  logic [WW-1:0]          work_head_q;
  logic [WCW-1:0]         work_cnt_q;
  logic [SCW-1:0]         scan_q;
  logic [SW-1:0]          rd_idx_q;
  logic                   found_q;
  logic [SW-1:0]          best_q;
  logic [QW-1:0]          best_age_q;
  logic [GW-1:0]          best_tag_q;
  logic [TW-1:0]          deadline_q;
  logic [GW-1:0]          tag_q;
  logic [1:0]             res_outc_q;
  logic [GW-1:0]          res_tag_q;
  logic [2:0]             res_timer_q;
  logic                   out_valid_q;
  logic [1:0]             out_outc_q;
  logic [GW-1:0]          out_tag_q;
  logic [2:0]             out_timer_q;
  logic [TW-1:0]          out_time_q;

  // memories
  tpwqs_pkg::slot_t slot_mem [TIMER_SLOTS];
  logic [SW-1:0]    idle_mem [TIMER_SLOTS];
  logic [GW-1:0]    work_mem [WORK_DEPTH];
  tpwqs_pkg::slot_t slot_rd_q;
  logic [SW-1:0]    idle_rd_q;
  logic [GW-1:0]    work_rd_q;

  logic           accept;
  logic           push_en;
  logic [SW-1:0]  push_slot;
  logic [SW-1:0]  idle_tail;
  logic [SCW:0]   idle_sum;
  logic [WW-1:0]  work_tail;
  logic [WCW:0]   work_sum;
  logic           post_en;
  logic [SW-1:0]  cid;
  logic           cancel_ok;
  logic [SW-1:0]  start_slot;
  logic [QW-1:0]  age;
  logic           expired;
  logic           out_free;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_o.ready;

  assign idle_sum  = (SCW+1)'(idle_head_q) + (SCW+1)'(idle_cnt_q);
  assign idle_tail = (idle_sum >= (SCW+1)'(TIMER_SLOTS)) ?
                     SW'(idle_sum - (SCW+1)'(TIMER_SLOTS)) : SW'(idle_sum);
  assign work_sum  = (WCW+1)'(work_head_q) + (WCW+1)'(work_cnt_q);
  assign work_tail = (work_sum >= (WCW+1)'(WORK_DEPTH)) ?
                     WW'(work_sum - (WCW+1)'(WORK_DEPTH)) : WW'(work_sum);

  assign cid       = SW'(in_i.timer_id);
  assign cancel_ok = (32'(in_i.timer_id) < TIMER_SLOTS) && active_q[cid];
  // an idle entry never written is not reset; its own index is used in its place
  assign start_slot = idle_wr_q[idle_head_q] ? idle_rd_q : idle_head_q;

  assign age     = seq_q - slot_rd_q.order;
  assign expired = active_q[rd_idx_q] && (slot_rd_q.deadline < tick_q);

  always_comb begin
    push_en   = 1'b0;
    push_slot = cid;
    post_en   = 1'b0;
    if (accept && in_i.operation == tpwqs_pkg::OP_CANCEL && cancel_ok) begin
      push_en = 1'b1;
    end else if (state_q == ST_DEC && found_q) begin
      push_en   = 1'b1;
      push_slot = best_q;
    end
    if (accept && in_i.operation == tpwqs_pkg::OP_POST &&
        32'(work_cnt_q) < WORK_DEPTH) begin
      post_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_START) begin
      slot_mem[start_slot] <= '{deadline: deadline_q, tag: tag_q, order: seq_q};
    end
    slot_rd_q <= slot_mem[scan_q[SW-1:0]];
    rd_idx_q  <= scan_q[SW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      idle_mem[idle_tail] <= push_slot;
    end
    idle_rd_q <= idle_mem[idle_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (post_en) begin
      work_mem[work_tail] <= in_i.action_tag;
    end
    work_rd_q <= work_mem[work_head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_wr_q <= '0;
    end else if (push_en) begin
      idle_wr_q[idle_tail] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      seq_q       <= '0;
      active_q    <= '0;
      idle_head_q <= '0;
      idle_cnt_q  <= SCW'(TIMER_SLOTS);
      work_head_q <= '0;
      work_cnt_q  <= '0;
      scan_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (push_en) begin
        active_q[push_slot] <= 1'b0;
        idle_cnt_q <= idle_cnt_q + 1'b1;
      end
      if (post_en) begin
        work_cnt_q <= work_cnt_q + 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            res_outc_q  <= tpwqs_pkg::OUTC_DONE;
            res_tag_q   <= '0;
            res_timer_q <= '0;
            state_q     <= ST_FIN;
            case (in_i.operation)
              tpwqs_pkg::OP_TICK: begin
                tick_q <= tick_q + 1'b1;
              end
              tpwqs_pkg::OP_START_REL, tpwqs_pkg::OP_START_ABS: begin
                if (idle_cnt_q == '0) begin
                  res_outc_q <= tpwqs_pkg::OUTC_ERROR;
                end else begin
                  deadline_q <= (in_i.operation == tpwqs_pkg::OP_START_REL) ?
                                tick_q + in_i.time_value : in_i.time_value;
                  tag_q      <= in_i.action_tag;
                  state_q    <= ST_START;
                end
              end
              tpwqs_pkg::OP_POST: begin
                if (!post_en) begin
                  res_outc_q <= tpwqs_pkg::OUTC_ERROR;
                end
              end
              tpwqs_pkg::OP_RUN: begin
                scan_q  <= '0;
                found_q <= 1'b0;
                state_q <= ST_SCAN;
              end
              tpwqs_pkg::OP_CANCEL: begin
                if (!cancel_ok) begin
                  res_outc_q <= tpwqs_pkg::OUTC_ERROR;
                end
              end
              default: begin
                res_outc_q <= tpwqs_pkg::OUTC_ERROR;
              end
            endcase
          end
        end
        ST_START: begin
          active_q[start_slot] <= 1'b1;
          idle_head_q <= (32'(idle_head_q) == TIMER_SLOTS - 1) ? '0 : idle_head_q + 1'b1;
          idle_cnt_q  <= idle_cnt_q - 1'b1;
          seq_q       <= seq_q + 1'b1;
          res_timer_q <= 3'(start_slot);
          state_q     <= ST_FIN;
        end
        ST_SCAN: begin
          // read of entry scan_q issued now, entry rd_idx_q evaluated
          if (scan_q != '0 && expired && (!found_q || age > best_age_q)) begin
            found_q    <= 1'b1;
            best_q     <= rd_idx_q;
            best_age_q <= age;
            best_tag_q <= slot_rd_q.tag;
          end
          if (32'(scan_q) == TIMER_SLOTS) begin
            state_q <= ST_DEC;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        ST_DEC: begin
          if (found_q) begin
            res_outc_q  <= tpwqs_pkg::OUTC_FIRED;
            res_tag_q   <= best_tag_q;
            res_timer_q <= 3'(best_q);
            state_q     <= ST_FIN;
          end else if (work_cnt_q != '0) begin
            state_q <= ST_WORK;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_WORK: begin
          res_outc_q  <= tpwqs_pkg::OUTC_WORK;
          res_tag_q   <= work_rd_q;
          work_head_q <= (32'(work_head_q) == WORK_DEPTH - 1) ? '0 : work_head_q + 1'b1;
          work_cnt_q  <= work_cnt_q - 1'b1;
          state_q     <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_outc_q  <= res_outc_q;
            out_tag_q   <= res_tag_q;
            out_timer_q <= res_timer_q;
            out_time_q  <= tick_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.outcome      = out_outc_q;
  assign out_o.result_tag   = out_tag_q;
  assign out_o.result_timer = out_timer_q;
  assign out_o.current_time = out_time_q;

`ifndef SYNTHESIS
  // every slot is either active or waiting in the idle FIFO
  a_slot_conserve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(active_q) + 32'(idle_cnt_q)) == TIMER_SLOTS)
    else $error("slot pool lost or duplicated a slot");

  a_work_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(work_cnt_q) <= WORK_DEPTH)
    else $error("work FIFO overfilled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("operation accepted while another is in flight");
`endif

endmodule
